/* design/hpq_pkg.sv */
// ----------------------------------------------------------------------------
// hpq_pkg
// Shared constants and types for the max-heap priority queue.
// ----------------------------------------------------------------------------
package hpq_pkg;

  localparam int CAPACITY = 64;
  // heap positions run 1..CAPACITY, memory addresses 0..CAPACITY-1
  localparam int POS_W    = $clog2(CAPACITY + 1);
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int DATA_W   = 32;

  typedef enum logic [1:0] {
    STATUS_DONE  = 2'd0,
    STATUS_EMPTY = 2'd1,
    STATUS_FULL  = 2'd2
  } status_e;

  typedef enum logic {
    CMD_INSERT = 1'b0,
    CMD_REMOVE = 1'b1
  } cmd_e;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [DATA_W-1:0] data;
  } hpq_wr_t;

endpackage

/* design/hpq_ram.sv */
// ----------------------------------------------------------------------------
// hpq_ram
// Heap storage: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module hpq_ram
  import hpq_pkg::*;
(
  input  logic              clk_i,
  input  hpq_wr_t           wr_i,
  input  logic [ADDR_W-1:0] rd_addr_i,
  output logic [DATA_W-1:0] rd_data_o
);

  logic [DATA_W-1:0] mem_q [CAPACITY];
  logic [DATA_W-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
    rd_data_q <= mem_q[rd_addr_i];
  end

  assign rd_data_o = rd_data_q;

endmodule

/* design/max_heap_priority_queue.sv */
// ----------------------------------------------------------------------------
// max_heap_priority_queue
// Binary max-heap of signed 32-bit values with insert and remove-maximum.
// ----------------------------------------------------------------------------
// One command is taken at a time; in_ready_o is low until its result beat has
// been taken. The heap lives in a single-port-read memory and one signed
// comparator is shared by every compare step of the sifting sequencer. An insert
// reads and compares the parent at each level it climbs; a remove reads the
// last entry, then at each level reads the left child, reads the right child,
// picks the larger, compares and writes back. A failed command goes straight
// to the result beat, which then holds the block until it is taken. Every
// memory access is paced by the one read port and its registered read data.
// The heap memory is not cleared at reset.
module max_heap_priority_queue
  import hpq_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        cmd_i,
  input  logic [31:0] value_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  status_o,
  output logic [31:0] removed_value_o,
  output logic [31:0] top_value_o,
  output logic [6:0]  entry_total_o
);

  typedef enum logic [3:0] {
    S_IDLE, S_UP_RD, S_UP_CMP, S_DN_LAST, S_DN_RDL,
    S_DN_RDR, S_DN_RCAP, S_DN_DEC, S_DONE
  } state_e;

  state_e            state_q;
  logic [POS_W-1:0]  count_q;
  logic [POS_W-1:0]  pos_q;
  logic [POS_W-1:0]  cpos_q;
  logic [DATA_W-1:0] val_q;
  logic [DATA_W-1:0] child_q;
  logic [DATA_W-1:0] top_q;
  logic [DATA_W-1:0] removed_q;
  status_e           status_q;

  hpq_wr_t           wr;
  logic [POS_W-1:0]  wr_pos;
  logic [POS_W-1:0]  rd_pos;
  logic [DATA_W-1:0] rd_data;
  logic [DATA_W-1:0] cmp_a;
  logic [DATA_W-1:0] cmp_b;
  logic              cmp_lt;
  logic [POS_W:0]    left;
  logic [POS_W:0]    right;
  logic [POS_W-1:0]  parent;
  logic              accept;

  assign left   = {pos_q, 1'b0};
  assign right  = left + (POS_W+1)'(1);
  assign parent = pos_q >> 1;
  assign accept = in_valid_i && in_ready_o;

  // shared signed comparator: cmp_lt is a < b
  always_comb begin
    cmp_a = rd_data;
    cmp_b = val_q;
    unique case (state_q)
      S_DN_RCAP: begin
        cmp_a = child_q;
        cmp_b = rd_data;
      end
      S_DN_DEC: begin
        cmp_a = val_q;
        cmp_b = child_q;
      end
      default: begin
        cmp_a = rd_data;
        cmp_b = val_q;
      end
    endcase
  end
  assign cmp_lt = $signed(cmp_a) < $signed(cmp_b);

  // read address by step
  always_comb begin
    unique case (state_q)
      S_UP_RD:  rd_pos = parent;
      S_DN_RDL: rd_pos = POS_W'(left);
      S_DN_RDR: rd_pos = POS_W'(right);
      default:  rd_pos = count_q;
    endcase
  end

  // write port: the carried value or a moved entry lands in the hole
  always_comb begin
    wr.en  = 1'b0;
    wr_pos = pos_q;
    wr.data = val_q;
    unique case (state_q)
      S_UP_RD: begin
        wr.en = (pos_q == POS_W'(1));
      end
      S_UP_CMP: begin
        wr.en   = 1'b1;
        wr.data = cmp_lt ? rd_data : val_q;
      end
      S_DN_RDL: begin
        wr.en = (left > {1'b0, count_q});
      end
      S_DN_DEC: begin
        wr.en   = 1'b1;
        wr.data = cmp_lt ? child_q : val_q;
      end
      default: begin
        wr.en = 1'b0;
      end
    endcase
    wr.addr = ADDR_W'(wr_pos - POS_W'(1));
  end

  hpq_ram u_ram (
    .clk_i     (clk_i),
    .wr_i      (wr),
    .rd_addr_i (ADDR_W'(rd_pos - POS_W'(1))),
    .rd_data_o (rd_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      count_q   <= '0;
      status_q  <= STATUS_DONE;
      pos_q     <= '0;
      cpos_q    <= '0;
      val_q     <= '0;
      child_q   <= '0;
      top_q     <= '0;
      removed_q <= '0;
    end else begin
      // root copy kept beside the memory for the top output
      if (wr.en && (wr_pos == POS_W'(1))) begin
        top_q <= wr.data;
      end
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            if (cmd_i == CMD_INSERT) begin
              removed_q <= '0;
              if (count_q == POS_W'(CAPACITY)) begin
                status_q <= STATUS_FULL;
                state_q  <= S_DONE;
              end else begin
                status_q <= STATUS_DONE;
                val_q    <= value_i;
                pos_q    <= count_q + POS_W'(1);
                count_q  <= count_q + POS_W'(1);
                state_q  <= S_UP_RD;
              end
            end else begin
              if (count_q == '0) begin
                removed_q <= '0;
                status_q  <= STATUS_EMPTY;
                state_q   <= S_DONE;
              end else begin
                removed_q <= top_q;
                status_q  <= STATUS_DONE;
                state_q   <= S_DN_LAST;
              end
            end
          end
        end
        S_UP_RD: begin
          state_q <= (pos_q == POS_W'(1)) ? S_DONE : S_UP_CMP;
        end
        S_UP_CMP: begin
          if (cmp_lt) begin
            pos_q   <= parent;
            state_q <= S_UP_RD;
          end else begin
            state_q <= S_DONE;
          end
        end
        S_DN_LAST: begin
          // last entry now carried down from the root
          val_q   <= rd_data;
          count_q <= count_q - POS_W'(1);
          pos_q   <= POS_W'(1);
          state_q <= (count_q == POS_W'(1)) ? S_DONE : S_DN_RDL;
        end
        S_DN_RDL: begin
          state_q <= (left > {1'b0, count_q}) ? S_DONE : S_DN_RDR;
        end
        S_DN_RDR: begin
          child_q <= rd_data;
          cpos_q  <= POS_W'(left);
          state_q <= (right <= {1'b0, count_q}) ? S_DN_RCAP : S_DN_DEC;
        end
        S_DN_RCAP: begin
          // right child wins only when strictly larger
          if (cmp_lt) begin
            child_q <= rd_data;
            cpos_q  <= POS_W'(right);
          end
          state_q <= S_DN_DEC;
        end
        S_DN_DEC: begin
          if (cmp_lt) begin
            pos_q   <= cpos_q;
            state_q <= S_DN_RDL;
          end else begin
            state_q <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_ready_i) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign in_ready_o      = (state_q == S_IDLE);
  assign out_valid_o     = (state_q == S_DONE);
  assign status_o        = status_q;
  assign removed_value_o = removed_q;
  assign top_value_o     = (count_q != '0) ? top_q : '0;
  assign entry_total_o   = 7'(count_q);

endmodule

/* tb/sv/max_heap_priority_queue_tb.sv */
// ----------------------------------------------------------------------------
// max_heap_priority_queue_tb
// Drives insert and remove-max beats into the heap queue and checks every
// result beat against a behavioral max-heap kept inside the bench.
// ----------------------------------------------------------------------------
module max_heap_priority_queue_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import hpq_pkg::*;

  typedef struct {
    status_e     status;
    logic [31:0] removed;
    logic [31:0] top;
    logic [6:0]  total;
  } heap_result_t;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic        cmd_i;
  logic [31:0] value_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [1:0]  status_o;
  logic [31:0] removed_value_o;
  logic [31:0] top_value_o;
  logic [6:0]  entry_total_o;

  // behavioral heap, positions 1..CAPACITY
  logic signed [31:0] model_heap [1:CAPACITY];
  int unsigned        model_count;
  heap_result_t       expected_results [$];
  int                 mismatch_count;
  bit                 steady;  // both sides run without idle cycles

  max_heap_priority_queue DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .cmd_i          (cmd_i),
    .value_i        (value_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .status_o       (status_o),
    .removed_value_o(removed_value_o),
    .top_value_o    (top_value_o),
    .entry_total_o  (entry_total_o)
  );

  always #5 clk_i = ~clk_i;

  task automatic swap_heap(input int unsigned a, input int unsigned b);
    logic signed [31:0] t;
    t             = model_heap[a];
    model_heap[a] = model_heap[b];
    model_heap[b] = t;
  endtask

  task automatic predict_heap(input cmd_e cmd, input logic [31:0] val);
    heap_result_t r;
    int unsigned  pos;
    int unsigned  left;
    int unsigned  best;
    r.status  = STATUS_DONE;
    r.removed = '0;
    if (cmd == CMD_INSERT) begin
      if (model_count >= CAPACITY) begin
        r.status = STATUS_FULL;
      end else begin
        model_count++;
        model_heap[model_count] = val;
        pos = model_count;
        // climb while the parent is strictly smaller
        while (pos > 1 && model_heap[pos / 2] < model_heap[pos]) begin
          swap_heap(pos / 2, pos);
          pos = pos / 2;
        end
      end
    end else begin
      if (model_count == 0) begin
        r.status = STATUS_EMPTY;
      end else begin
        r.removed     = model_heap[1];
        model_heap[1] = model_heap[model_count];
        model_count--;
        pos = 1;
        forever begin
          left = 2 * pos;
          best = pos;
          if (left <= model_count && model_heap[best] < model_heap[left])
            best = left;
          // left wins ties with right
          if (left + 1 <= model_count && model_heap[best] < model_heap[left + 1])
            best = left + 1;
          if (best == pos) break;
          swap_heap(best, pos);
          pos = best;
        end
      end
    end
    r.top   = (model_count > 0) ? model_heap[1] : '0;
    r.total = model_count[6:0];
    expected_results.push_back(r);
  endtask

  // called right after a rising edge; returns at the edge that takes the beat
  task automatic send_cmd(input cmd_e cmd, input logic [31:0] val);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 3);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    cmd_i      <= cmd;
    value_i    <= val;
    do @(negedge clk_i); while (!in_ready_o);
    @(posedge clk_i);
    predict_heap(cmd, val);
  endtask

  task automatic test_empty_remove();
    send_cmd(CMD_REMOVE, 32'h1234_5678);
    send_cmd(CMD_REMOVE, 32'hffff_ffff);
  endtask

  task automatic test_extremes();
    send_cmd(CMD_INSERT, 32'h0000_0000);
    send_cmd(CMD_INSERT, 32'h7fff_ffff);
    send_cmd(CMD_INSERT, 32'h8000_0000);
    send_cmd(CMD_INSERT, 32'hffff_ffff);
    send_cmd(CMD_INSERT, 32'h0000_0001);
    repeat (6) send_cmd(CMD_REMOVE, 32'h0);
  endtask

  task automatic test_equal_keys();
    send_cmd(CMD_INSERT, 32'd5);
    send_cmd(CMD_INSERT, 32'd5);
    send_cmd(CMD_INSERT, 32'd5);
    send_cmd(CMD_INSERT, 32'd3);
    send_cmd(CMD_INSERT, 32'd5);
    repeat (5) send_cmd(CMD_REMOVE, 32'h0);
  endtask

  // phases lean toward insert or remove so the heap runs full and empty
  task automatic test_random();
    int          insert_pct [6] = '{90, 50, 15, 90, 15, 50};
    logic [31:0] val;
    cmd_e        cmd;
    for (int phase = 0; phase < 6; phase++) begin
      steady = (phase == 1 || phase == 4);
      repeat (150) begin
        cmd = ($urandom_range(0, 99) < insert_pct[phase]) ? CMD_INSERT : CMD_REMOVE;
        case ($urandom_range(0, 9))
          0:       val = 32'h7fff_ffff;
          1:       val = 32'h8000_0000;
          2, 3:    val = $urandom_range(0, 8) - 4;  // narrow range gives ties
          default: val = $urandom;
        endcase
        send_cmd(cmd, val);
      end
    end
    steady = 1'b0;
  endtask

  initial begin : result_monitor
    heap_result_t exp_r;
    heap_result_t act_r;
    int           stall;
    @(posedge clk_i iff rst_ni);
    forever begin
      stall = steady ? 0 : $urandom_range(0, 3);
      if (stall != 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(negedge clk_i); while (!out_valid_o);
      act_r.status  = status_e'(status_o);
      act_r.removed = removed_value_o;
      act_r.top     = top_value_o;
      act_r.total   = entry_total_o;
      @(posedge clk_i);
      if (expected_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("%0t: unexpected result beat status=%0d removed=%0d top=%0d total=%0d",
                   $realtime, act_r.status, $signed(act_r.removed),
                   $signed(act_r.top), act_r.total);
      end else begin
        exp_r = expected_results.pop_front();
        if (act_r.status !== exp_r.status || act_r.removed !== exp_r.removed ||
            act_r.top !== exp_r.top || act_r.total !== exp_r.total) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display({"%0t: mismatch exp status=%0d removed=%0d top=%0d total=%0d",
                      " got status=%0d removed=%0d top=%0d total=%0d"},
                     $realtime, exp_r.status, $signed(exp_r.removed),
                     $signed(exp_r.top), exp_r.total, act_r.status,
                     $signed(act_r.removed), $signed(act_r.top), act_r.total);
        end
      end
    end
  end

  initial begin
    clk_i          = 1'b0;
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    cmd_i          = CMD_INSERT;
    value_i        = '0;
    out_ready_i    = 1'b0;
    model_count    = 0;
    mismatch_count = 0;
    steady         = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_remove();
    test_extremes();
    test_equal_keys();
    test_random();

    in_valid_i <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin : watchdog
    #5ms;
    $display("TEST FAILED");
    $finish;
  end

endmodule

/* sim.f */
design/hpq_pkg.sv
design/hpq_ram.sv
design/max_heap_priority_queue.sv
tb/sv/max_heap_priority_queue_tb.sv
